// ===== hw/rtl/far_pkg.sv =====
// far_pkg: shared types and codes for the fraction arithmetic reducer
// no dependencies
package far_pkg;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_DEN_ZERO  = 2'd1,
    STATUS_ZERO_ZERO = 2'd2,
    STATUS_RSVD      = 2'd3
  } status_e;

  // commands from controller to datapath
  typedef struct packed {
    logic load;      // capture operands
    logic prod;      // form the first product pair
    logic prod2;     // form the second product pair
    logic combine;   // combine products into n and d
    logic div_start; // start the shared divider
    logic div_euclid;// divider is running a euclid step (else reduction)
    logic div_den;   // divider reduces the denominator (else the numerator)
    logic step;      // take a euclid step with the divider remainder
    logic red_num;   // store quotient as reduced numerator
    logic red_den;   // store quotient as reduced denominator
  } far_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic y_zero;    // euclid divisor is zero
    logic g_zero;    // gcd is zero
    logic div_done;  // divider finished
  } far_sts_t;

endpackage

// ===== hw/rtl/far_divider.sv =====
// far_divider: iterative signed truncating divider, one quotient bit a cycle
// depends on far_pkg
module far_divider
  import far_pkg::*;
#(
  parameter int unsigned W = 33
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [W-1:0] dividend_i,
  input  logic signed [W-1:0] divisor_i,
  output logic                done_o,
  output logic signed [W-1:0] quot_o,
  output logic signed [W-1:0] rem_o
);

  localparam int unsigned CW = $clog2(W + 1);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [W-1:0]  quo_q, rem_q, dvs_q;
  logic          qneg_q, rneg_q;
  logic [W:0]    trial;
  logic [W-1:0]  shl;

  // restoring step on magnitudes
  assign shl   = {rem_q[W-2:0], quo_q[W-1]};
  assign trial = {1'b0, shl} - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // magnitude registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q  <= dividend_i[W-1] ? W'(-dividend_i) : dividend_i;
      dvs_q  <= divisor_i[W-1] ? W'(-divisor_i) : divisor_i;
      rem_q  <= '0;
      qneg_q <= dividend_i[W-1] ^ divisor_i[W-1];
      rneg_q <= dividend_i[W-1];
    end else if (busy_q) begin
      if (!trial[W]) begin
        rem_q <= trial[W-1:0];
        quo_q <= {quo_q[W-2:0], 1'b1};
      end else begin
        rem_q <= shl;
        quo_q <= {quo_q[W-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = qneg_q ? -$signed(quo_q) : $signed(quo_q);
  assign rem_o  = rneg_q ? -$signed(rem_q) : $signed(rem_q);

endmodule

// ===== hw/rtl/far_datapath.sv =====
// far_datapath: operand registers, multiplier, euclid registers and reduction
// depends on far_pkg and far_divider
module far_datapath
  import far_pkg::*;
#(
  parameter int unsigned OW = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  far_cmd_t               cmd_i,
  output far_sts_t               sts_o,
  input  logic [1:0]             command_i,
  input  logic signed [OW-1:0]   num_a_i,
  input  logic signed [OW-1:0]   den_a_i,
  input  logic signed [OW-1:0]   num_b_i,
  input  logic signed [OW-1:0]   den_b_i,
  output logic signed [2*OW:0]   result_num_o,
  output logic signed [2*OW:0]   result_den_o,
  output logic [1:0]             status_o
);

  localparam int unsigned RW = 2 * OW + 1;

  logic [1:0]            cmd_q;
  logic signed [OW-1:0]  na_q, da_q, nb_q, db_q;
  logic signed [2*OW-1:0] p1_q, p2_q, pd_q;
  logic signed [RW-1:0]  n_q, d_q, x_q, y_q, rn_q, rd_q;
  logic signed [RW-1:0]  dvd, dvs, quot, rem;
  logic signed [OW-1:0]  ma, mb;
  logic                  done;

  // multiplier operand mux for the prod and prod2 states; the denominator product has its own
  always_comb begin
    if (cmd_i.prod) begin
      ma = na_q;
      mb = (cmd_q == CMD_MUL) ? nb_q : db_q;
    end else begin
      ma = (cmd_q == CMD_DIV) ? da_q : nb_q;
      mb = (cmd_q == CMD_DIV) ? nb_q : da_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q <= command_i;
      na_q  <= num_a_i;
      da_q  <= den_a_i;
      nb_q  <= num_b_i;
      db_q  <= den_b_i;
    end
    if (cmd_i.prod) p1_q <= ma * mb;
    if (cmd_i.prod2) p2_q <= ma * mb;
    // denominator product for add, sub, mul
    if (cmd_i.prod) pd_q <= da_q * db_q;
    if (cmd_i.combine) begin
      case (cmd_q)
        CMD_ADD: n_q <= RW'(p1_q) + RW'(p2_q);
        CMD_SUB: n_q <= RW'(p1_q) - RW'(p2_q);
        default: n_q <= RW'(p1_q);
      endcase
      d_q <= (cmd_q == CMD_DIV) ? RW'(p2_q) : RW'(pd_q);
      x_q <= (cmd_q == CMD_ADD) ? RW'(p1_q) + RW'(p2_q) :
             (cmd_q == CMD_SUB) ? RW'(p1_q) - RW'(p2_q) : RW'(p1_q);
      y_q <= (cmd_q == CMD_DIV) ? RW'(p2_q) : RW'(pd_q);
    end
    if (cmd_i.step) begin
      x_q <= y_q;
      y_q <= rem;
    end
    if (cmd_i.red_num) rn_q <= quot;
    if (cmd_i.red_den) rd_q <= quot;
  end

  // divider inputs: euclid step or reduction by the gcd in x
  always_comb begin
    if (cmd_i.div_euclid) begin
      dvd = x_q;
      dvs = y_q;
    end else if (cmd_i.div_den) begin
      dvd = d_q;
      dvs = x_q;
    end else begin
      dvd = n_q;
      dvs = x_q;
    end
  end

  far_divider #(.W(RW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dvd),
    .divisor_i  (dvs),
    .done_o     (done),
    .quot_o     (quot),
    .rem_o      (rem)
  );

  assign sts_o.y_zero   = (y_q == '0);
  assign sts_o.g_zero   = (x_q == '0);
  assign sts_o.div_done = done;

  // result selection
  always_comb begin
    if (x_q == '0) begin
      result_num_o = n_q;
      result_den_o = d_q;
      status_o     = STATUS_ZERO_ZERO;
    end else begin
      result_num_o = rn_q;
      result_den_o = rd_q;
      status_o     = (rd_q == '0) ? STATUS_DEN_ZERO : STATUS_OK;
    end
  end

endmodule

// ===== hw/rtl/far_ctrl.sv =====
// far_ctrl: sequencer for products, euclid loop and reduction
// depends on far_pkg
module far_ctrl
  import far_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output far_cmd_t cmd_o,
  input  far_sts_t sts_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_PROD, S_PROD2, S_COMB, S_CHECK, S_EUC, S_RNUM_GO, S_RNUM,
    S_RDEN_GO, S_RDEN, S_OUT
  } state_e;

  state_e state_q;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  // command decode
  always_comb begin
    cmd_o            = '0;
    cmd_o.load       = in_valid_i && (state_q == S_IDLE);
    cmd_o.prod       = (state_q == S_PROD);
    cmd_o.prod2      = (state_q == S_PROD2);
    cmd_o.combine    = (state_q == S_COMB);
    cmd_o.div_start  = ((state_q == S_CHECK) && !sts_i.y_zero) ||
                       (state_q == S_RNUM_GO) || (state_q == S_RDEN_GO);
    cmd_o.div_euclid = (state_q == S_CHECK) || (state_q == S_EUC);
    cmd_o.div_den    = (state_q == S_RDEN_GO);
    cmd_o.step       = (state_q == S_EUC) && sts_i.div_done;
    cmd_o.red_num    = (state_q == S_RNUM) && sts_i.div_done;
    cmd_o.red_den    = (state_q == S_RDEN) && sts_i.div_done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      case (state_q)
        S_IDLE:  if (in_valid_i) state_q <= S_PROD;
        S_PROD:  state_q <= S_PROD2;
        S_PROD2: state_q <= S_COMB;
        S_COMB:  state_q <= S_CHECK;
        S_CHECK: begin
          if (!sts_i.y_zero) state_q <= S_EUC;
          else if (sts_i.g_zero) state_q <= S_OUT;
          else state_q <= S_RNUM_GO;
        end
        S_EUC:     if (sts_i.div_done) state_q <= S_CHECK;
        S_RNUM_GO: state_q <= S_RNUM;
        S_RNUM:    if (sts_i.div_done) state_q <= S_RDEN_GO;
        S_RDEN_GO: state_q <= S_RDEN;
        S_RDEN:    if (sts_i.div_done) state_q <= S_OUT;
        S_OUT:     if (out_ready_i) state_q <= S_IDLE;
        default:   state_q <= S_IDLE;
      endcase
    end
  end

  // a finished division only arrives while waiting for one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> (state_q == S_EUC || state_q == S_RNUM || state_q == S_RDEN))
    else $error("divider done outside a wait state");
  // intake never overlaps delivery
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("ready and valid together");
  // a euclid step starts only with a nonzero divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.div_start && cmd_o.div_euclid) |-> !sts_i.y_zero)
    else $error("euclid step with zero divisor");

endmodule

// ===== hw/rtl/fraction_arithmetic_reducer.sv =====
// fraction_arithmetic_reducer: top level, one item at a time.
// flow: load, two product states, combine, euclid loop, then the numerator and the
// denominator are divided by the gcd on the shared divider, one quotient bit a cycle.
// a new item is taken only after the result handshake returns the controller to idle.
// reset: asynchronous active low, returns the controller to idle; no result pending.
// depends on far_pkg, far_ctrl, far_datapath
module fraction_arithmetic_reducer
  import far_pkg::*;
#(
  parameter int unsigned OPERAND_WIDTH = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // command[1:0], num_a, den_a, num_b, den_b, zero pad
  input  logic [((4*OPERAND_WIDTH+2+7)/8)*8-1:0] s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // result_num, result_den, status, zero pad
  output logic [((4*OPERAND_WIDTH+4+7)/8)*8-1:0] m_axis_tdata
);

  localparam int unsigned OW  = OPERAND_WIDTH;
  localparam int unsigned RW  = 2 * OW + 1;
  localparam int unsigned OBW = ((4*OW+4+7)/8)*8;

  far_cmd_t cmd;
  far_sts_t sts;
  logic signed [RW-1:0] rnum, rden;
  logic [1:0] status;

  far_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  far_datapath #(.OW(OW)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .command_i    (s_axis_tdata[1:0]),
    .num_a_i      (s_axis_tdata[2+OW-1:2]),
    .den_a_i      (s_axis_tdata[2+2*OW-1:2+OW]),
    .num_b_i      (s_axis_tdata[2+3*OW-1:2+2*OW]),
    .den_b_i      (s_axis_tdata[2+4*OW-1:2+3*OW]),
    .result_num_o (rnum),
    .result_den_o (rden),
    .status_o     (status)
  );

  assign m_axis_tdata = OBW'({status, rden, rnum});

endmodule
